// ===== design/mgwe_pkg.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// mgwe_pkg
// Shared types, codes and helpers of the matched group weight engine.
//------------------------------------------------------------------------------
package mgwe_pkg;

   localparam int CntW    = 20;
   localparam int WeightW = 32;
   localparam int MaskW   = 16;
   localparam int DivW    = CntW + 16;

   localparam int MAX_GROUPS_DEF     = 1024;
   localparam int MAX_TREATMENTS_DEF = 16;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_FINISH = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_TRT = 2'd1;
   localparam logic [1:0] STATUS_BAD_GRP = 2'd2;

   localparam logic [1:0] KIND_NUMBER    = 2'd0;
   localparam logic [1:0] KIND_NA_UNM    = 2'd1;
   localparam logic [1:0] KIND_NA_MISS   = 2'd2;

   localparam logic [1:0] REG_NUM_TRT    = 2'd0;
   localparam logic [1:0] REG_NUM_GRP    = 2'd1;
   localparam logic [1:0] REG_ALL_TGT    = 2'd2;
   localparam logic [1:0] REG_UNASG_NA   = 2'd3;

   localparam logic [CntW-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic [1:0] command;
      logic [3:0] treatment;
      logic [9:0] group;
      logic       unmatched;
      logic [3:0] add;
      logic [1:0] status;
   } item_type;

   typedef struct packed {
      logic [4:0] nt;
      logic       unassigned_is_na;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [WeightW-1:0] weight;
      logic [1:0]         kind;
      logic [CntW-1:0]    total;
      logic [MaskW-1:0]   mask;
      logic               unm_targets;
   } rsp_type;

   function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                               input logic [CntW-1:0] b);
      logic [CntW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CntW] ? CNT_MAX : s[CntW-1:0];
   endfunction

endpackage

// ===== design/mgwe_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// mgwe_fifo
// Two-entry queue of classified commands between front and back.
//------------------------------------------------------------------------------
module mgwe_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mgwe_pkg::item_type push_item,
   input  wire logic              pop,
   output mgwe_pkg::item_type     head,
   output logic                   empty,
   output logic                   full
);
   import mgwe_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== design/mgwe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// mgwe_front
// Register port, input beat acceptance and range classification.
//------------------------------------------------------------------------------
module mgwe_front #(
   parameter int MAX_GROUPS     = mgwe_pkg::MAX_GROUPS_DEF,
   parameter int MAX_TREATMENTS = mgwe_pkg::MAX_TREATMENTS_DEF,
   parameter int NGW            = $clog2(MAX_GROUPS + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [23:0]        req_tdata,
   input  wire logic [1:0]         req_tuser,
   input  wire logic               busy,
   input  wire logic               q_full,
   output logic                    push,
   output mgwe_pkg::item_type      push_item,
   output mgwe_pkg::cfg_type       cfg,
   output logic [NGW-1:0]          ng
);
   import mgwe_pkg::*;

   localparam int TrtLim = (MAX_TREATMENTS < 16) ? MAX_TREATMENTS : 16;

   logic [4:0]  num_trt_ff, num_trt_in;
   logic [10:0] num_grp_ff, num_grp_in;
   logic        all_tgt_ff, all_tgt_in;
   logic        una_na_ff, una_na_in;
   logic        wr_en;
   logic [4:0]  nt;
   logic [3:0]  t;
   logic [9:0]  g;
   logic        unm;
   logic [3:0]  mult;

   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      num_trt_in = num_trt_ff;
      num_grp_in = num_grp_ff;
      all_tgt_in = all_tgt_ff;
      una_na_in  = una_na_ff;
      if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_NUM_TRT:  num_trt_in = csr_pwdata[4:0];
            REG_NUM_GRP:  num_grp_in = csr_pwdata[10:0];
            REG_ALL_TGT:  all_tgt_in = csr_pwdata[0];
            REG_UNASG_NA: una_na_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_NUM_TRT:  csr_prdata = {27'd0, num_trt_ff};
         REG_NUM_GRP:  csr_prdata = {21'd0, num_grp_ff};
         REG_ALL_TGT:  csr_prdata = {31'd0, all_tgt_ff};
         REG_UNASG_NA: csr_prdata = {31'd0, una_na_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_trt_ff <= 5'd2;
         num_grp_ff <= 11'd1024;
         all_tgt_ff <= 1'b1;
         una_na_ff  <= 1'b0;
      end else begin
         num_trt_ff <= num_trt_in;
         num_grp_ff <= num_grp_in;
         all_tgt_ff <= all_tgt_in;
         una_na_ff  <= una_na_in;
      end
   end

   always_comb begin
      if (num_trt_ff < 5'd2) nt = 5'd2;
      else if (32'(num_trt_ff) > TrtLim) nt = 5'(TrtLim);
      else nt = num_trt_ff;
      if (num_grp_ff == 11'd0) ng = NGW'(1);
      else if (32'(num_grp_ff) > MAX_GROUPS) ng = NGW'(MAX_GROUPS);
      else ng = NGW'(num_grp_ff);
   end

   assign cfg.nt               = nt;
   assign cfg.unassigned_is_na = una_na_ff;

   assign t    = req_tdata[3:0];
   assign g    = req_tdata[13:4];
   assign unm  = req_tdata[14];
   assign mult = req_tdata[18:15];

   assign req_tready = ~busy & ~q_full;
   assign push       = req_tvalid & req_tready;

   always_comb begin
      push_item.command   = req_tuser;
      push_item.treatment = t;
      push_item.group     = g;
      push_item.unmatched = unm;
      push_item.add       = all_tgt_ff ? 4'd1 : mult;
      push_item.status    = STATUS_OK;
      if (req_tuser == CMD_LOAD || req_tuser == CMD_QUERY) begin
         if ({1'b0, t} >= nt) push_item.status = STATUS_BAD_TRT;
         else if (!unm && 32'(g) >= 32'(ng)) push_item.status = STATUS_BAD_GRP;
      end
   end

endmodule
`default_nettype wire

// ===== design/mgwe_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// mgwe_div
// Restoring divider, one quotient bit per cycle, saturated to Q16.16.
//------------------------------------------------------------------------------
module mgwe_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [mgwe_pkg::CntW-1:0]    tc,
   input  wire logic [mgwe_pkg::CntW-1:0]    divisor,
   output logic                              done,
   output logic [mgwe_pkg::WeightW-1:0]      weight
);
   import mgwe_pkg::*;

   localparam int StepW = $clog2(DivW + 1);

   logic [DivW-1:0]  num_ff, num_in;
   logic [CntW-1:0]  rem_ff, rem_in;
   logic [CntW-1:0]  dsr_ff, dsr_in;
   logic [StepW-1:0] step_ff, step_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CntW:0]    trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[DivW-1]};
      if (start) begin
         num_in  = {tc, 16'd0};
         rem_in  = '0;
         dsr_in  = divisor;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial[CntW-1:0] - dsr_ff;
            num_in = {num_ff[DivW-2:0], 1'b1};
         end else begin
            rem_in = trial[CntW-1:0];
            num_in = {num_ff[DivW-2:0], 1'b0};
         end
         step_in = step_ff + StepW'(1);
         if (step_ff == StepW'(DivW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      step_ff <= step_in;
   end

   assign done   = done_ff;
   assign weight = (num_ff[DivW-1:WeightW] != '0) ? '1 : num_ff[WeightW-1:0];

endmodule
`default_nettype wire

// ===== design/mgwe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// mgwe_back
// Count store, finish walk, clearing pass, query sequencing and result beat.
//------------------------------------------------------------------------------
module mgwe_back #(
   parameter int MAX_GROUPS     = mgwe_pkg::MAX_GROUPS_DEF,
   parameter int MAX_TREATMENTS = mgwe_pkg::MAX_TREATMENTS_DEF,
   parameter int NGW            = $clog2(MAX_GROUPS + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mgwe_pkg::cfg_type   cfg,
   input  wire logic [NGW-1:0]      ng,
   input  wire mgwe_pkg::item_type  head,
   input  wire logic                q_empty,
   output logic                     pop,
   output logic                     busy,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output mgwe_pkg::rsp_type        rsp
);
   import mgwe_pkg::*;

   localparam int AW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int TrtLim = (MAX_TREATMENTS < 16) ? MAX_TREATMENTS : 16;

   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_FRD  = 3'd3;
   localparam logic [2:0] ST_FAC  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;

   typedef logic [MAX_TREATMENTS-1:0][CntW-1:0] row_type;

   logic [CntW-1:0] gtc_mem  [MAX_GROUPS];
   row_type         pair_mem [MAX_GROUPS];

   logic [2:0]      state_ff, state_in;
   item_type        item_ff, item_in;
   logic [CntW-1:0] tc_rd_ff;
   row_type         row_rd_ff;
   logic [CntW-1:0] unm_ff, unm_in;
   logic [MaskW-1:0] mask_ff, mask_in;
   logic [CntW-1:0] total_ff, total_in;
   logic [CntW-1:0] acc_tot_ff, acc_tot_in;
   logic [MaskW-1:0] acc_mask_ff, acc_mask_in;
   logic [NGW-1:0]  walk_ff, walk_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic            clr_rsp_ff, clr_rsp_in;
   logic            out_v_ff, out_v_in;
   rsp_type         out_ff, out_in;

   logic [AW-1:0]   rd_addr;
   logic            we;
   logic [AW-1:0]   wr_addr;
   logic [CntW-1:0] gtc_wr;
   row_type         row_wr;
   logic [CntW-1:0] lane_cc;
   logic            emit;
   logic [1:0]      e_kind;
   logic [WeightW-1:0] e_weight;
   logic            div_start;
   logic            div_done;
   logic [WeightW-1:0] div_weight;

   mgwe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .tc      (tc_rd_ff),
      .divisor (lane_cc),
      .done    (div_done),
      .weight  (div_weight)
   );

   always_comb begin
      lane_cc = '0;
      for (int i = 0; i < MAX_TREATMENTS; i++) begin
         if (i == int'(item_ff.treatment)) lane_cc = row_rd_ff[i];
      end
   end

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      unm_in      = unm_ff;
      mask_in     = mask_ff;
      total_in    = total_ff;
      acc_tot_in  = acc_tot_ff;
      acc_mask_in = acc_mask_ff;
      walk_in     = walk_ff;
      clr_in      = clr_ff;
      clr_rsp_in  = clr_rsp_ff;
      pop         = 1'b0;
      rd_addr     = AW'(item_ff.group);
      we          = 1'b0;
      wr_addr     = AW'(item_ff.group);
      gtc_wr      = '0;
      row_wr      = '0;
      emit        = 1'b0;
      e_kind      = KIND_NUMBER;
      e_weight    = '0;
      div_start   = 1'b0;
      unique case (state_ff)
         ST_CLR: begin
            we      = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_GROUPS - 1)) begin
               clr_in     = '0;
               state_in   = ST_IDLE;
               emit       = clr_rsp_ff;
               clr_rsp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            rd_addr = AW'(head.group);
            if (!q_empty && !out_v_ff) begin
               pop     = 1'b1;
               item_in = head;
               if (head.command == CMD_CLEAR) begin
                  unm_in     = '0;
                  mask_in    = '0;
                  total_in   = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = ST_CLR;
               end else if (head.command == CMD_FINISH) begin
                  walk_in     = '0;
                  acc_tot_in  = '0;
                  acc_mask_in = '0;
                  state_in    = ST_FRD;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            emit     = 1'b1;
            if (item_ff.status == STATUS_OK) begin
               if (item_ff.command == CMD_LOAD) begin
                  if (item_ff.unmatched) begin
                     unm_in = sat_add(unm_ff, CntW'(item_ff.add));
                  end else begin
                     we     = 1'b1;
                     gtc_wr = sat_add(tc_rd_ff, CntW'(item_ff.add));
                     row_wr = row_rd_ff;
                     for (int i = 0; i < MAX_TREATMENTS; i++) begin
                        if (i == int'(item_ff.treatment)) begin
                           row_wr[i] = sat_add(row_rd_ff[i], CntW'(1));
                        end
                     end
                  end
               end else begin
                  if (item_ff.unmatched) begin
                     e_kind = cfg.unassigned_is_na ? KIND_NA_UNM : KIND_NUMBER;
                  end else if (mask_ff[item_ff.treatment]) begin
                     e_kind = KIND_NA_MISS;
                  end else if (tc_rd_ff != '0) begin
                     if (lane_cc == '0) begin
                        e_kind = KIND_NA_MISS;
                     end else begin
                        emit      = 1'b0;
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
               end
            end
         end
         ST_FRD: begin
            rd_addr  = walk_ff[AW-1:0];
            state_in = ST_FAC;
         end
         ST_FAC: begin
            acc_tot_in = sat_add(acc_tot_ff, tc_rd_ff);
            if (tc_rd_ff != '0) begin
               for (int i = 0; i < TrtLim; i++) begin
                  if (i < int'(cfg.nt) && row_rd_ff[i] == '0) acc_mask_in[i] = 1'b1;
               end
            end
            walk_in = walk_ff + NGW'(1);
            if (walk_in == ng) begin
               total_in = acc_tot_in;
               mask_in  = acc_mask_in;
               emit     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FRD;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               e_weight = div_weight;
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      out_v_in = out_v_ff & ~rsp_tready;
      out_in   = out_ff;
      if (emit) begin
         out_v_in           = 1'b1;
         out_in.status      = item_ff.status;
         out_in.weight      = e_weight;
         out_in.kind        = e_kind;
         out_in.total       = total_in;
         out_in.mask        = mask_in;
         out_in.unm_targets = (unm_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         out_v_ff   <= 1'b0;
         unm_ff     <= '0;
         mask_ff    <= '0;
         total_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         out_v_ff   <= out_v_in;
         unm_ff     <= unm_in;
         mask_ff    <= mask_in;
         total_ff   <= total_in;
      end
      item_ff     <= item_in;
      acc_tot_ff  <= acc_tot_in;
      acc_mask_ff <= acc_mask_in;
      walk_ff     <= walk_in;
      out_ff      <= out_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         gtc_mem[wr_addr]  <= gtc_wr;
         pair_mem[wr_addr] <= row_wr;
      end
      tc_rd_ff  <= gtc_mem[rd_addr];
      row_rd_ff <= pair_mem[rd_addr];
   end

   assign busy       = (state_ff == ST_CLR);
   assign rsp_tvalid = out_v_ff;
   assign rsp        = out_ff;

endmodule
`default_nettype wire

// ===== design/matched_group_weight_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
//------------------------------------------------------------------------------
// matched_group_weight_engine
// Per-group target and per-(treatment, group) counts with Q16.16 weight query.
//
//   port group   dir   beat contents
//   req_*        in    command, treatment, group, unmatched, multiplicity
//   rsp_*        out   status, weight, kind, total, mask, unmatched flag
//   csr_*        in    treatment count, group count, target mode,
//                      unassigned na select
//
// from accept to rsp_tvalid: a load reads and updates its group, a query reads
// its group and may run the 36-step divider, finish walks every configured
// group of the store, and clear runs the clearing pass.
// after reset a clearing pass over all MAX_GROUPS entries runs before req_tready
// rises; clear commands run the same pass. a two-entry queue keeps taking
// beats while a result waits on rsp_tready, until the queue is full.
//------------------------------------------------------------------------------
module matched_group_weight_engine #(
   parameter int MAX_GROUPS     = mgwe_pkg::MAX_GROUPS_DEF,
   parameter int MAX_TREATMENTS = mgwe_pkg::MAX_TREATMENTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // treatment[3:0], group[13:4], unmatched[14], target_multiplicity[18:15]
   input  wire logic [23:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], weight[33:2], total_targets[53:34], missing_mask[69:54],
   // unmatched_targets[70]
   output logic [71:0]      rsp_tdata,
   // weight_kind[1:0]
   output logic [1:0]       rsp_tuser
);
   import mgwe_pkg::*;

   localparam int NGW = $clog2(MAX_GROUPS + 1);

   logic           busy;
   logic           q_full;
   logic           q_empty;
   logic           push;
   logic           pop;
   item_type       push_item;
   item_type       head;
   cfg_type        cfg;
   logic [NGW-1:0] ng;
   rsp_type        rsp;

   assign csr_pready = 1'b1;

   mgwe_front #(
      .MAX_GROUPS     (MAX_GROUPS),
      .MAX_TREATMENTS (MAX_TREATMENTS),
      .NGW            (NGW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .busy        (busy),
      .q_full      (q_full),
      .push        (push),
      .push_item   (push_item),
      .cfg         (cfg),
      .ng          (ng)
   );

   mgwe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   mgwe_back #(
      .MAX_GROUPS     (MAX_GROUPS),
      .MAX_TREATMENTS (MAX_TREATMENTS),
      .NGW            (NGW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .ng         (ng),
      .head       (head),
      .q_empty    (q_empty),
      .pop        (pop),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.unm_targets, rsp.mask, rsp.total, rsp.weight, rsp.status};
   assign rsp_tuser = rsp.kind;

endmodule
`default_nettype wire
